// ===== hw/rtl/pnm_pkg.sv =====
// shared types and constants for the netpbm stream decoder
`default_nettype none
package pnm_pkg;
   localparam int DIM_BITS = 16;
   localparam logic [16:0] VAL_SAT = 17'd65536;
   localparam logic [16:0] DIM_MAX = 17'((64'd1 << DIM_BITS) - 64'd1);

   typedef enum logic [1:0] {
      KIND_PIXEL  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // work item from the parser front to the scaling back end
   typedef enum logic [1:0] {
      OP_ERROR  = 2'd0,
      OP_HEADER = 2'd1,
      OP_SAMPLE = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] sample;
      logic        emit;      // sample completes a pixel
      logic        last;
      logic [15:0] width;
      logic [15:0] height;
      logic        gray;
      logic [15:0] maxval;
   } job_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_of_image;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        gray_source;
      logic        last_pixel;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/pnm_if.sv =====
// valid/ready channel interface
`default_nettype none
interface pnm_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pnm_binary_stream_decoder.sv =====
// top level of the netpbm P5/P6 stream decoder
`default_nettype none
// Takes one file byte per beat on req and returns header, error and RGB pixel
// beats on rsp. Header bytes are parsed at one byte per cycle while the queue
// has room; each raster sample is scaled by a 24-step restoring divider, and no
// new sample is taken until it is done. A two-entry queue separates the parser
// from the divider, and the cycle after maxval is spent forming width*height.
module pnm_binary_stream_decoder (
   input  wire logic clock,
   input  wire logic reset,
   pnm_if.sink       req,
   pnm_if.source     rsp
);
   import pnm_pkg::*;
   logic    fj_valid, q_nf, q_ne, b_ready;
   job_type fj_data, q_data;

   pnm_front u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .job_valid(fj_valid), .job_ready(q_nf), .job_data(fj_data)
   );
   pnm_queue u_queue (
      .clock, .reset, .push(fj_valid), .push_data(fj_data), .not_full(q_nf),
      .not_empty(q_ne), .pop(q_ne && b_ready), .pop_data(q_data)
   );
   pnm_back u_back (
      .clock, .reset, .job_valid(q_ne), .job_ready(b_ready), .job_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      fj_valid |-> q_nf) else $error("push into full queue");
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data.kind == KIND_ERROR) |-> (rsp.data.image_width == 16'd0))
      else $error("error beat carries width");
endmodule
`default_nettype wire

// ===== hw/rtl/pnm_front.sv =====
// header parser and sample framer
`default_nettype none
module pnm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire pnm_pkg::req_type in_data,
   output logic                  job_valid,
   input  wire logic             job_ready,
   output pnm_pkg::job_type      job_data
);
   import pnm_pkg::*;

   typedef enum logic [2:0] {
      PH_MAGIC_P, PH_MAGIC_D, PH_HEADER, PH_COMMENT, PH_PIXELS, PH_DONE, PH_ERROR
   } phase_type;
   typedef enum logic [1:0] {TK_IDLE, TK_SIGN, TK_DIGITS, TK_STOPPED} tok_type;

   phase_type   phase_ff, phase_in;
   tok_type     tok_ff, tok_in;
   logic        gray_ff, gray_in;
   logic [16:0] val_ff, val_in;
   logic [1:0]  fcnt_ff, fcnt_in;
   logic [15:0] width_ff, width_in, height_ff, height_in, max_ff, max_in;
   logic [7:0]  hi_ff, hi_in;
   logic [2:0]  bph_ff, bph_in;
   logic [31:0] left_ff, left_in;
   // pixel count product is taken in the cycle after the header ends
   logic        mul_pend_ff, mul_pend_in;
   logic        emit;
   job_type     job;
   logic [7:0]  b;
   logic        ws, dig, two;
   logic [20:0] tv;
   logic [16:0] v;
   logic [31:0] left_dec;

   assign in_ready = job_ready && !mul_pend_ff;
   assign job_valid = in_valid && in_ready && emit;
   assign job_data = job;

   always_comb begin
      phase_in = phase_ff; tok_in = tok_ff; gray_in = gray_ff; val_in = val_ff;
      fcnt_in = fcnt_ff; width_in = width_ff; height_in = height_ff; max_in = max_ff;
      hi_in = hi_ff; bph_in = bph_ff; left_in = left_ff; mul_pend_in = 1'b0;
      emit = 1'b0;
      b = in_data.data_byte;
      if (in_data.start_of_image) begin
         phase_in = PH_MAGIC_P; tok_in = TK_IDLE; gray_in = 1'b0; val_in = '0;
         fcnt_in = '0; width_in = '0; height_in = '0; max_in = '0;
         hi_in = '0; bph_in = '0; left_in = '0;
      end
      ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
      dig = (b >= 8'h30) && (b <= 8'h39);
      two = max_in > 16'd255;
      tv = 21'({val_in, 3'b000}) + 21'({val_in, 1'b0}) + 21'(b - 8'h30);
      v = val_in;
      left_dec = (left_in != 32'd0) ? left_in - 32'd1 : left_in;
      job = '0;
      job.width = width_in; job.height = height_in; job.gray = gray_in;
      job.maxval = max_in;
      job.last = (left_dec == 32'd0);
      unique case (phase_in)
         PH_MAGIC_P: begin
            if (b != 8'h50) begin emit = 1'b1; phase_in = PH_ERROR; end
            else phase_in = PH_MAGIC_D;
         end
         PH_MAGIC_D: begin
            if (b != 8'h35 && b != 8'h36) begin emit = 1'b1; phase_in = PH_ERROR; end
            else begin gray_in = (b == 8'h35); phase_in = PH_HEADER; end
         end
         PH_HEADER: begin
            if (b == 8'h00) begin emit = 1'b1; phase_in = PH_ERROR; end
            else if (tok_in == TK_IDLE) begin
               if (b == 8'h23) phase_in = PH_COMMENT;
               else if (!ws) begin
                  val_in = dig ? 17'(b - 8'h30) : '0;
                  tok_in = dig ? TK_DIGITS : (b == 8'h2B ? TK_SIGN : TK_STOPPED);
               end
            end else if (ws) begin
               tok_in = TK_IDLE; val_in = '0;
               if (v < 17'd1 || v > 17'd65535) begin emit = 1'b1; phase_in = PH_ERROR; end
               else if (fcnt_in == 2'd0) begin
                  if (v > DIM_MAX) begin emit = 1'b1; phase_in = PH_ERROR; end
                  else begin width_in = v[15:0]; fcnt_in = 2'd1; end
               end else if (fcnt_in == 2'd1) begin
                  if (v > DIM_MAX) begin emit = 1'b1; phase_in = PH_ERROR; end
                  else begin height_in = v[15:0]; fcnt_in = 2'd2; end
               end else begin
                  max_in = v[15:0]; fcnt_in = 2'd3; bph_in = '0;
                  phase_in = PH_PIXELS; mul_pend_in = 1'b1; emit = 1'b1;
                  job.op = OP_HEADER; job.maxval = v[15:0];
               end
            end else if (dig && tok_in != TK_STOPPED) begin
               val_in = (tv > 21'(VAL_SAT)) ? VAL_SAT : tv[16:0];
               tok_in = TK_DIGITS;
            end else tok_in = TK_STOPPED;
         end
         PH_COMMENT: begin
            if (b == 8'h00) begin emit = 1'b1; phase_in = PH_ERROR; end
            else if (b == 8'h0A) phase_in = PH_HEADER;
         end
         PH_PIXELS: begin
            if (two && !bph_in[0]) begin
               hi_in = b; bph_in = bph_in + 3'd1;
            end else begin
               emit = 1'b1;
               job.op = OP_SAMPLE;
               job.sample = two ? {hi_in, b} : {8'h00, b};
               if (gray_in || (two ? bph_in[2:1] : bph_in[1:0]) == 2'd2) begin
                  job.emit = 1'b1; bph_in = '0; left_in = left_dec;
                  if (left_dec == 32'd0) phase_in = PH_DONE;
               end else bph_in = bph_in + 3'd1;
            end
         end
         PH_DONE, PH_ERROR: ;
         default: ;
      endcase
      if (job.op == OP_ERROR) job.width = '0;
      if (job.op == OP_ERROR) job.height = '0;
      if (job.op == OP_ERROR) job.gray = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC_P; tok_ff <= TK_IDLE; gray_ff <= 1'b0; val_ff <= '0;
         fcnt_ff <= '0; width_ff <= '0; height_ff <= '0; max_ff <= '0;
         hi_ff <= '0; bph_ff <= '0; left_ff <= '0; mul_pend_ff <= 1'b0;
      end else begin
         mul_pend_ff <= 1'b0;
         if (mul_pend_ff) left_ff <= width_ff * height_ff;
         if (in_valid && in_ready) begin
            phase_ff <= phase_in; tok_ff <= tok_in; gray_ff <= gray_in;
            val_ff <= val_in; fcnt_ff <= fcnt_in; width_ff <= width_in;
            height_ff <= height_in; max_ff <= max_in; hi_ff <= hi_in;
            bph_ff <= bph_in; left_ff <= left_in; mul_pend_ff <= mul_pend_in;
         end
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/pnm_queue.sv =====
// two-entry job queue between parser and back end
`default_nettype none
module pnm_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire pnm_pkg::job_type push_data,
   output logic                  not_full,
   output logic                  not_empty,
   input  wire logic             pop,
   output pnm_pkg::job_type      pop_data
);
   import pnm_pkg::*;
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign not_full = cnt_ff != 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/pnm_back.sv =====
// sample scaling by a serial divider and pixel assembly
`default_nettype none
module pnm_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output logic                  job_ready,
   input  wire pnm_pkg::job_type job_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output pnm_pkg::rsp_type      out_data
);
   import pnm_pkg::*;
   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FINISH} state_type;

   state_type   state_ff;
   job_type     job_ff;
   logic [23:0] num_ff;
   logic [23:0] quo_ff;
   logic [23:0] rem_ff;
   logic [4:0]  cnt_ff;
   logic [1:0]  chan_ff;
   logic [7:0]  red_ff, green_ff;
   logic        ovalid_ff;
   rsp_type     odata_ff;
   logic [24:0] rtry;
   logic [7:0]  sc;

   assign job_ready = (state_ff == ST_IDLE) && (!ovalid_ff || out_ready);
   assign out_valid = ovalid_ff;
   assign out_data = odata_ff;
   assign rtry = {rem_ff, num_ff[23]} - {9'd0, job_ff.maxval};
   assign sc = (job_ff.maxval == 16'd0) ? 8'd0 : ((|quo_ff[23:8]) ? 8'd255 : quo_ff[7:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ovalid_ff <= 1'b0; chan_ff <= '0;
      end else begin
         if (ovalid_ff && out_ready) ovalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (job_valid && job_ready) begin
               job_ff <= job_data;
               if (job_data.op == OP_SAMPLE) begin
                  // sample*255 = (s<<8) - s
                  num_ff <= {job_data.sample, 8'd0} - {8'd0, job_data.sample};
                  rem_ff <= '0; quo_ff <= '0; cnt_ff <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  ovalid_ff <= 1'b1;
                  chan_ff <= '0;
                  odata_ff.kind <= (job_data.op == OP_HEADER) ? KIND_HEADER : KIND_ERROR;
                  odata_ff.red <= '0;
                  odata_ff.green <= '0;
                  odata_ff.blue <= '0;
                  odata_ff.image_width <= job_data.width;
                  odata_ff.image_height <= job_data.height;
                  odata_ff.gray_source <= job_data.gray;
                  odata_ff.last_pixel <= 1'b0;
               end
            end
            ST_DIV: begin
               num_ff <= {num_ff[22:0], 1'b0};
               if (!rtry[24]) begin
                  rem_ff <= rtry[23:0]; quo_ff <= {quo_ff[22:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[22:0], num_ff[23]}; quo_ff <= {quo_ff[22:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd23) state_ff <= ST_FINISH;
            end
            ST_FINISH: if (!ovalid_ff || out_ready) begin
               state_ff <= ST_IDLE;
               if (job_ff.gray || job_ff.emit) begin
                  ovalid_ff <= 1'b1;
                  chan_ff <= '0;
                  odata_ff.kind <= KIND_PIXEL;
                  odata_ff.red <= job_ff.gray ? sc : red_ff;
                  odata_ff.green <= job_ff.gray ? sc : green_ff;
                  odata_ff.blue <= sc;
                  odata_ff.image_width <= job_ff.width;
                  odata_ff.image_height <= job_ff.height;
                  odata_ff.gray_source <= job_ff.gray;
                  odata_ff.last_pixel <= job_ff.last;
               end else begin
                  if (chan_ff == 2'd0) red_ff <= sc; else green_ff <= sc;
                  chan_ff <= chan_ff + 2'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== tb/pnm_tb_if.sv =====
// the decoder testbench uses the rtl pnm_if valid/ready channel interface directly
`default_nettype none
`default_nettype wire

// ===== tb/pnm_binary_stream_decoder_tb.sv =====
// testbench for the netpbm stream decoder: self-checking with a built-in predictor
`default_nettype none
module pnm_binary_stream_decoder_tb;
   import pnm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] PH_MAGIC_P = 4'd0, PH_MAGIC_D = 4'd1, PH_HEADER = 4'd2,
                          PH_COMMENT = 4'd3, PH_PIXELS = 4'd4, PH_DONE = 4'd5,
                          PH_ERROR = 4'd6;
   localparam logic [1:0] TK_IDLE = 2'd0, TK_SIGN = 2'd1, TK_DIGITS = 2'd2,
                          TK_STOPPED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   pnm_if #(.payload_type(req_type)) req ();
   pnm_if #(.payload_type(rsp_type)) rsp ();

   pnm_binary_stream_decoder DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      forever #6 clock = ~clock;
   end

   // decoder state mirror
   logic [3:0]  phase;
   logic        is_gray;
   logic [16:0] tok_val;
   logic [1:0]  tok_state;
   logic [1:0]  fields;
   logic [15:0] wid, hgt, maxv;
   logic [7:0]  hi_byte, r_hold, g_hold;
   logic [2:0]  bphase;
   logic [31:0] remaining;

   req_type byte_queue[$];
   rsp_type pixel_queue[$];
   int      errors = 0;
   int      n_pixels = 0, n_headers = 0, n_errs = 0;
   bit      stim_done = 0;
   bit      hold_sink = 0;

   function automatic bit is_space(logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   task automatic clear_decoder();
      phase = PH_MAGIC_P; is_gray = 0; tok_val = 0; tok_state = TK_IDLE; fields = 0;
      wid = 0; hgt = 0; maxv = 0; hi_byte = 0; bphase = 0; r_hold = 0; g_hold = 0;
      remaining = 0;
   endtask

   function automatic rsp_type blank_rsp(kind_type k);
      rsp_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   function automatic logic [7:0] scale(logic [15:0] n);
      logic [31:0] v;
      if (maxv == 0) return 8'd0;
      v = (32'(n) * 32'd255) / 32'(maxv);
      return v > 255 ? 8'd255 : v[7:0];
   endfunction

   task automatic push_error();
      phase = PH_ERROR;
      pixel_queue.push_back(blank_rsp(KIND_ERROR));
   endtask

   task automatic end_field();
      logic [16:0] v;
      rsp_type     r;
      v = tok_val;
      tok_state = TK_IDLE;
      tok_val = 0;
      if (v < 1 || v > 17'd65535 || (fields < 2 && v > DIM_MAX)) begin
         push_error();
      end else if (fields == 0) begin
         wid = v[15:0]; fields = 1;
      end else if (fields == 1) begin
         hgt = v[15:0]; fields = 2;
      end else begin
         maxv = v[15:0]; fields = 3;
         remaining = 32'(wid) * 32'(hgt);
         bphase = 0;
         phase = PH_PIXELS;
         r = blank_rsp(KIND_HEADER);
         r.image_width = wid; r.image_height = hgt; r.gray_source = is_gray;
         pixel_queue.push_back(r);
      end
   endtask

   task automatic header_char(logic [7:0] b);
      bit dig;
      dig = b >= 8'h30 && b <= 8'h39;
      if (b == 0) begin
         push_error();
      end else if (tok_state == TK_IDLE) begin
         if (b == 8'h23) phase = PH_COMMENT;
         else if (!is_space(b)) begin
            tok_val = dig ? 17'(b - 8'h30) : 17'd0;
            tok_state = dig ? TK_DIGITS : (b == 8'h2B ? TK_SIGN : TK_STOPPED);
         end
      end else if (is_space(b)) begin
         end_field();
      end else if (dig && tok_state != TK_STOPPED) begin
         if (32'(tok_val) * 10 + 32'(b - 8'h30) > 32'(VAL_SAT)) tok_val = VAL_SAT;
         else tok_val = tok_val * 10 + 17'(b - 8'h30);
         tok_state = TK_DIGITS;
      end else begin
         tok_state = TK_STOPPED;
      end
   endtask

   task automatic raster_char(logic [7:0] b);
      bit          two;
      logic [15:0] n;
      logic [2:0]  idx;
      logic [7:0]  v;
      rsp_type     r;
      two = maxv > 255;
      if (two && !bphase[0]) begin
         hi_byte = b; bphase = bphase + 3'd1;
         return;
      end
      n = two ? {hi_byte, b} : {8'd0, b};
      idx = two ? bphase >> 1 : bphase;
      v = scale(n);
      r = blank_rsp(KIND_PIXEL);
      if (is_gray) begin
         r.red = v; r.green = v; r.blue = v;
      end else if (idx == 0) begin
         r_hold = v; bphase = bphase + 3'd1;
         return;
      end else if (idx == 1) begin
         g_hold = v; bphase = bphase + 3'd1;
         return;
      end else begin
         r.red = r_hold; r.green = g_hold; r.blue = v;
      end
      bphase = 0;
      r.image_width = wid; r.image_height = hgt; r.gray_source = is_gray;
      if (remaining != 0) remaining--;
      if (remaining == 0) begin
         r.last_pixel = 1; phase = PH_DONE;
      end
      pixel_queue.push_back(r);
   endtask

   task automatic decode_byte(req_type it);
      if (it.start_of_image) clear_decoder();
      case (phase)
         PH_MAGIC_P: begin
            if (it.data_byte != 8'h50) push_error();
            else phase = PH_MAGIC_D;
         end
         PH_MAGIC_D: begin
            if (it.data_byte != 8'h35 && it.data_byte != 8'h36) push_error();
            else begin
               is_gray = it.data_byte == 8'h35;
               phase = PH_HEADER;
            end
         end
         PH_HEADER: header_char(it.data_byte);
         PH_COMMENT: begin
            if (it.data_byte == 0) push_error();
            else if (it.data_byte == 8'h0A) phase = PH_HEADER;
         end
         PH_PIXELS: raster_char(it.data_byte);
         default: ;
      endcase
   endtask

   // stimulus building
   bit first_of_file;

   task automatic put(logic [7:0] b);
      req_type it;
      it.data_byte = b;
      it.start_of_image = first_of_file;
      first_of_file = 0;
      byte_queue.push_back(it);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endtask

   function automatic logic [7:0] rand_space();
      return ($urandom_range(0, 5) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
   endfunction

   task automatic put_sep();
      int k;
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++) put(rand_space());
      if ($urandom_range(0, 4) == 0) begin
         put_text("#c");
         put(8'($urandom_range(1, 255) | 8'h80));
         put(8'h0A);
         put(rand_space());
      end
   endtask

   task automatic put_file(bit gray, int w, int h, int mv, int raster_bytes);
      first_of_file = 1;
      put_text(gray ? "P5" : "P6");
      put_sep(); put_text($sformatf("%0d", w));
      put_sep(); put_text($sformatf("%0d", h));
      put_sep(); put_text($sformatf("%0d", mv));
      put(rand_space());
      for (int i = 0; i < raster_bytes; i++) put(8'($urandom));
   endtask

   task automatic put_good_file();
      bit gray;
      int w, h, mv, per;
      gray = $urandom_range(0, 1);
      w = $urandom_range(1, 3);
      h = $urandom_range(1, 2);
      case ($urandom_range(0, 3))
         0: mv = 255;
         1: mv = $urandom_range(1, 255);
         2: mv = $urandom_range(256, 65535);
         default: mv = 65535;
      endcase
      per = (gray ? 1 : 3) * (mv > 255 ? 2 : 1);
      put_file(gray, w, h, mv, w * h * per + $urandom_range(0, 1) * 2);
   endtask

   task automatic put_noise();
      int k;
      k = $urandom_range(1, 12);
      first_of_file = 1;
      if ($urandom_range(0, 1)) put_text("P");
      if ($urandom_range(0, 1)) put(8'($urandom_range(32'h35, 32'h36)));
      for (int i = 0; i < k; i++) put(8'($urandom));
   endtask

   initial begin
      first_of_file = 1;
      // directed: bad magic, bad digit, zero byte, signs, overflow, junk suffix
      put(8'h00); put(8'hFF);
      first_of_file = 1; put_text("P7");
      first_of_file = 1; put_text("P5 +2 1x #z\n 255\n"); put(8'hFF); put(8'h00); put(8'h11);
      first_of_file = 1; put_text("P6 -1 ");
      first_of_file = 1; put_text("P5 99999 ");
      first_of_file = 1; put_text("P6 1 1 65535 "); for (int i = 0; i < 6; i++) put(8'hFF);
      first_of_file = 1; put_text("P5 1 #"); put(8'h00);
      first_of_file = 1; put_text("P5 1 1 0 ");
      first_of_file = 1; put_text("P5 1 1 1\t"); put(8'h80);
   end

   // driver
   req_type cur;
   int      gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.data <= '0;
      end else begin
         if (req.valid && req.ready) decode_byte(req.data);
         if ((!req.valid || req.ready)) begin
            if (gap > 0) begin
               gap <= gap - 1;
               req.valid <= 1'b0;
            end else if (byte_queue.size() > 0 && !(byte_queue[0].data_byte === 8'hxx)) begin
               cur = byte_queue.pop_front();
               req.data <= cur;
               req.valid <= 1'b1;
               gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and rsp ready
   int      sink_wait = 0;
   int      hold_cnt = 0;
   rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pixel_queue.size() == 0) begin
               $error("unexpected beat kind=%0d", rsp.data.kind);
               errors++;
            end else begin
               want = pixel_queue.pop_front();
               case (want.kind)
                  KIND_PIXEL: n_pixels++;
                  KIND_HEADER: n_headers++;
                  default: n_errs++;
               endcase
               if (rsp.data.kind !== want.kind) begin
                  $error("kind exp %0d got %0d", want.kind, rsp.data.kind); errors++; end
               if (rsp.data.red !== want.red) begin
                  $error("red exp %0d got %0d", want.red, rsp.data.red); errors++; end
               if (rsp.data.green !== want.green) begin
                  $error("green exp %0d got %0d", want.green, rsp.data.green); errors++; end
               if (rsp.data.blue !== want.blue) begin
                  $error("blue exp %0d got %0d", want.blue, rsp.data.blue); errors++; end
               if (rsp.data.image_width !== want.image_width) begin
                  $error("image_width exp %0d got %0d", want.image_width,
                         rsp.data.image_width); errors++; end
               if (rsp.data.image_height !== want.image_height) begin
                  $error("image_height exp %0d got %0d", want.image_height,
                         rsp.data.image_height); errors++; end
               if (rsp.data.gray_source !== want.gray_source) begin
                  $error("gray_source exp %0d got %0d", want.gray_source,
                         rsp.data.gray_source); errors++; end
               if (rsp.data.last_pixel !== want.last_pixel) begin
                  $error("last_pixel exp %0d got %0d", want.last_pixel,
                         rsp.data.last_pixel); errors++; end
            end
         end
         if (hold_sink && hold_cnt < 400) begin
            hold_cnt <= hold_cnt + 1;
            rsp.ready <= 1'b0;
         end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if (rsp.valid && rsp.ready)
               sink_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
         end
      end
   end

   // main sequence
   initial begin
      clear_decoder();
      req.valid = 1'b0; req.data = '0; rsp.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (byte_queue.size() == 0);
      // long sink stall while a file keeps streaming in
      put_file(1'b0, 3, 2, 300, 36);
      hold_sink = 1;
      wait (byte_queue.size() == 0);
      wait (hold_cnt >= 400);
      // sender pause until all results drained
      wait (byte_queue.size() == 0 && !req.valid);
      wait (pixel_queue.size() == 0);
      while (byte_queue.size() < 750) begin
         if ($urandom_range(0, 5) == 0) put_noise();
         else put_good_file();
      end
      wait (byte_queue.size() == 0 && !req.valid);
      @(posedge clock);
      wait (pixel_queue.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d pixels, %0d headers, %0d format errors",
               n_pixels, n_headers, n_errs);
      if (errors == 0 && pixel_queue.size() == 0) begin
         $display("PASS pnm_binary_stream_decoder");
      end else begin
         $display("FAIL pnm_binary_stream_decoder");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("FAIL pnm_binary_stream_decoder");
      $finish;
   end
endmodule
`default_nettype wire
